FILE: hw/rtl/ils_pkg.sv
// Shared types and codes for the indexed list store.
package ils_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_DROP   = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_FIND   = 3'd5
  } ils_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } ils_status_t;

  // Per-cycle update broadcast to every cell.
  typedef struct packed {
    logic ins;  // open a slot at idx, move higher entries up one cell
    logic del;  // close the slot at idx, move higher entries down one cell
  } ils_shift_t;

  localparam int OPERATION_W      = 3;
  localparam int VALUE_W          = 32;
  localparam int POSITION_W       = 7;
  localparam int READ_VALUE_W     = 32;
  localparam int FOUND_POSITION_W = 6;
  localparam int COUNT_W          = 7;
  localparam int STATUS_W         = 2;

endpackage

FILE: hw/rtl/ils_cell.sv
// One storage cell of the list: holds one element and one hop of the scan chain.
module ils_cell #(
  parameter int IDX   = 0,
  parameter int EW    = 32,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  ils_pkg::ils_shift_t shift_i,
  input  logic [CNT_W-1:0]    idx_i,
  input  logic [EW-1:0]       value_i,
  input  logic [EW-1:0]       left_i,
  input  logic [EW-1:0]       right_i,
  output logic [EW-1:0]       data_o,
  input  logic                find_i,
  input  logic [CNT_W-1:0]    pos_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [EW-1:0]       key_i,
  input  logic                hit_i,
  input  logic [IDX_W-1:0]    hidx_i,
  input  logic [EW-1:0]       hdata_i,
  output logic                hit_o,
  output logic [IDX_W-1:0]    hidx_o,
  output logic [EW-1:0]       hdata_o
);
  import ils_pkg::*;

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [EW-1:0]    data_r, data_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hidx_r, hidx_nxt;
  logic [EW-1:0]    hdata_r, hdata_nxt;
  logic             sel;

  always_comb begin
    data_nxt = data_r;
    if (shift_i.ins) begin
      if (MY_POS == idx_i) begin
        data_nxt = value_i;
      end else if (MY_POS > idx_i) begin
        data_nxt = left_i;
      end
    end else if (shift_i.del) begin
      if (MY_POS >= idx_i) begin
        data_nxt = right_i;
      end
    end
  end

  // Lower cells overwrite the carry, so the first match survives to cell 0.
  assign sel = find_i ? ((MY_POS < count_i) && (data_r == key_i)) : (MY_POS == pos_i);

  always_comb begin
    hit_nxt   = hit_i;
    hidx_nxt  = hidx_i;
    hdata_nxt = hdata_i;
    if (sel) begin
      hit_nxt   = 1'b1;
      hidx_nxt  = MY_IDX;
      hdata_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    hit_r   <= hit_nxt;
    hidx_r  <= hidx_nxt;
    hdata_r <= hdata_nxt;
  end

  assign data_o  = data_r;
  assign hit_o   = hit_r;
  assign hidx_o  = hidx_r;
  assign hdata_o = hdata_r;

endmodule

FILE: hw/rtl/indexed_list_store.sv
// Top level of the indexed list store: controller and row of storage cells.
//
// An ordered list of up to CAPACITY elements lives in a row of cells, one
// element per cell. Append, insert and remove act on all cells at once in
// the accept cycle: insert moves every entry above the position up one
// cell, remove moves them down one cell; drop only lowers the count. A
// result beat for these is offered the cycle after the input beat. Read and
// find send a carry record down the row, one cell per cycle, from the top
// cell to cell 0; each cell replaces the record when it holds the wanted
// position or a matching value, so the lowest match wins. A read or find
// item holds the block for that whole walk. One item is in flight at a
// time; in_stall stays high from the input beat until its result beat is
// taken. Element storage is not cleared by reset; the count, state and hop
// counter are.
module indexed_list_store #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ils_pkg::OPERATION_W-1:0]       in_operation,
  input  logic [ils_pkg::VALUE_W-1:0]           in_value,
  input  logic [ils_pkg::POSITION_W-1:0]        in_position,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ils_pkg::READ_VALUE_W-1:0]      out_read_value,
  output logic                                  out_found,
  output logic [ils_pkg::FOUND_POSITION_W-1:0]  out_found_position,
  output logic [ils_pkg::COUNT_W-1:0]           out_count,
  output logic                                  out_empty_res,
  output logic [ils_pkg::STATUS_W-1:0]          out_status
);
  import ils_pkg::*;

  localparam int EW    = ELEMENT_WIDTH;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
  localparam logic [CMP_W-1:0] CAP_C  = CMP_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_C = IDX_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  ils_op_t          op_r;
  ils_status_t      status_r, status_nxt;
  logic [EW-1:0]    key_r;
  logic [CNT_W-1:0] pos_r;
  logic [IDX_W-1:0] hop_r;

  logic             in_beat, out_beat, ok;
  ils_op_t          op_in;
  logic [CMP_W-1:0] pos_c, cnt_c;
  logic [63:0]      val64;
  logic [EW-1:0]    val_e;
  ils_shift_t       shift;
  logic [CNT_W-1:0] shift_idx;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign op_in = ils_op_t'(in_operation);
  assign pos_c = CMP_W'(in_position);
  assign cnt_c = CMP_W'(count_r);
  assign val64 = {32'd0, in_value};
  assign val_e = val64[EW-1:0];

  // Check the operation against the current count; a failed one changes nothing.
  always_comb begin
    status_nxt = ST_OK;
    unique case (in_operation)
      OP_APPEND: begin
        if (cnt_c >= CAP_C) status_nxt = ST_FULL;
      end
      OP_DROP: begin
        if (cnt_c == '0) status_nxt = ST_EMPTY;
      end
      OP_INSERT: begin
        if (cnt_c >= CAP_C) status_nxt = ST_FULL;
        else if (pos_c > cnt_c) status_nxt = ST_RANGE;
      end
      OP_REMOVE, OP_READ: begin
        if (cnt_c == '0) status_nxt = ST_EMPTY;
        else if (pos_c >= cnt_c) status_nxt = ST_RANGE;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  assign ok = (status_nxt == ST_OK);

  // Append is an insert at the current count.
  always_comb begin
    shift     = '0;
    shift_idx = pos_c[CNT_W-1:0];
    count_nxt = count_r;
    if (in_beat && ok) begin
      case (op_in)
        OP_APPEND: begin
          shift.ins = 1'b1;
          shift_idx = count_r;
          count_nxt = count_r + 1'b1;
        end
        OP_INSERT: begin
          shift.ins = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        OP_REMOVE: begin
          shift.del = 1'b1;
          count_nxt = count_r - 1'b1;
        end
        OP_DROP: begin
          count_nxt = count_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      hop_r   <= '0;
    end else begin
      count_r <= count_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            hop_r <= '0;
            if ((op_in == OP_READ) || (op_in == OP_FIND)) state_r <= S_SCAN;
            else state_r <= S_OUT;
          end
        end
        S_SCAN: begin
          // Advance until the carry has walked through every cell.
          if (hop_r == LAST_C) state_r <= S_OUT;
          else hop_r <= hop_r + 1'b1;
        end
        S_OUT: begin
          if (out_beat) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (in_beat) begin
      op_r     <= op_in;
      status_r <= status_nxt;
      key_r    <= val_e;
      pos_r    <= pos_c[CNT_W-1:0];
    end
  end

  // Cell row. Carry index k feeds cell k-1; the top input is an empty record.
  logic [EW-1:0]    data_w  [CAPACITY];
  logic [EW-1:0]    left_w  [CAPACITY];
  logic [EW-1:0]    right_w [CAPACITY];
  logic             hit_w   [CAPACITY+1];
  logic [IDX_W-1:0] hidx_w  [CAPACITY+1];
  logic [EW-1:0]    hdata_w [CAPACITY+1];

  assign hit_w[CAPACITY]   = 1'b0;
  assign hidx_w[CAPACITY]  = '0;
  assign hdata_w[CAPACITY] = '0;

  logic find_sel;
  assign find_sel = (op_r == OP_FIND);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_lo
      assign left_w[i] = '0;
    end else begin : g_lo_n
      assign left_w[i] = data_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_w[i] = '0;
    end else begin : g_hi_n
      assign right_w[i] = data_w[i+1];
    end

    ils_cell #(
      .IDX   (i),
      .EW    (EW),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .shift_i (shift),
      .idx_i   (shift_idx),
      .value_i (val_e),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .data_o  (data_w[i]),
      .find_i  (find_sel),
      .pos_i   (pos_r),
      .count_i (count_r),
      .key_i   (key_r),
      .hit_i   (hit_w[i+1]),
      .hidx_i  (hidx_w[i+1]),
      .hdata_i (hdata_w[i+1]),
      .hit_o   (hit_w[i]),
      .hidx_o  (hidx_w[i]),
      .hdata_o (hdata_w[i])
    );
  end

  // Result beat: held stable while out_stall is high.
  logic [63:0] rd64;
  logic [15:0] fp16;
  logic [15:0] cnt16;
  logic        found;

  assign found = find_sel && hit_w[0];

  always_comb begin
    rd64 = '0;
    if ((op_r == OP_READ) && (status_r == ST_OK)) rd64[EW-1:0] = hdata_w[0];
    fp16 = '0;
    if (found) fp16[IDX_W-1:0] = hidx_w[0];
    cnt16 = '0;
    cnt16[CNT_W-1:0] = count_r;
  end

  assign out_valid          = (state_r == S_OUT);
  assign out_read_value     = rd64[READ_VALUE_W-1:0];
  assign out_found          = found;
  assign out_found_position = fp16[FOUND_POSITION_W-1:0];
  assign out_count          = cnt16[COUNT_W-1:0];
  assign out_empty_res      = (count_r == '0);
  assign out_status         = status_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CAP_C)
    else $error("list count above capacity");

  a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(count_r))
    else $error("count changed while an item was in flight");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status_r == ST_FULL)) |-> (CMP_W'(count_r) == CAP_C))
    else $error("full reported below capacity");

  a_result_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result beat is pending");

  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (hop_r == LAST_C) |=> out_valid)
    else $error("scan did not end after the last cell");
`endif

endmodule
